/* hdl/mtfc_pkg.sv */
`timescale 1ns / 1ps

package mtfc_pkg;

   localparam int ALPHABET_SIZE = 256;
   localparam int IDX_W         = $clog2(ALPHABET_SIZE);
   localparam int VALUE_W       = 8;
   localparam int VALUE_MAX     = 255;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [VALUE_W-1:0] value_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_WALK,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic fetch;
      logic walk;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic decode;
      logic stop;
   } stat_type;

   // Decode positions past the end of the list land on the last entry.
   function automatic idx_type sat_pos(value_type v);
      if (32'(v) >= ALPHABET_SIZE) begin
         return IDX_W'(ALPHABET_SIZE - 1);
      end else begin
         return IDX_W'(v);
      end
   endfunction

   function automatic value_type sat_value(idx_type idx);
      if (32'(idx) > VALUE_MAX) begin
         return VALUE_W'(VALUE_MAX);
      end else begin
         return VALUE_W'(idx);
      end
   endfunction

endpackage

/* hdl/mtfc_req_if.sv */
`timescale 1ns / 1ps

interface mtfc_req_if;
   import mtfc_pkg::*;

   logic      valid;
   logic      ready;
   value_type value_in;
   logic      last_in;

   modport source (output valid, output value_in, output last_in, input ready);
   modport sink (input valid, input value_in, input last_in, output ready);
endinterface

/* hdl/mtfc_rsp_if.sv */
`timescale 1ns / 1ps

interface mtfc_rsp_if;
   import mtfc_pkg::*;

   logic      valid;
   logic      ready;
   value_type value_out;
   logic      last_out;

   modport source (output valid, output value_out, output last_out, input ready);
   modport sink (input valid, input value_out, input last_out, output ready);
endinterface

/* hdl/mtfc_ram.sv */
`timescale 1ns / 1ps

module mtfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/mtfc_datapath.sv */
`timescale 1ns / 1ps

module mtfc_datapath
   import mtfc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_write_en,
   input  logic      csr_write_data,
   input  cmd_type   cmd,
   output stat_type  stat,
   input  value_type req_value,
   input  logic      req_last,
   output value_type rsp_value,
   output logic      rsp_last
);

   logic                     mode_ff, mode_in;
   idx_type                  pos_ff, pos_in;
   logic                     last_ff, last_in;
   value_type                sym_ff, sym_in;
   value_type                carry_ff, carry_in;
   idx_type                  idx_ff, idx_in;
   idx_type                  rd_addr_ff;
   logic                     rd_valid_ff, rd_valid_in;
   logic [ALPHABET_SIZE-1:0] valid_ff, valid_in;
   value_type                rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in;

   idx_type   rd_addr;
   value_type ram_rdata;
   value_type rd_data;
   logic      wr_en;
   logic      stop;

   mtfc_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (ALPHABET_SIZE)
   ) u_list (
      .clock (clock),
      .we    (wr_en),
      .waddr (idx_ff),
      .wdata (carry_ff),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   always_comb begin
      // An entry never written since the last block end holds its own index.
      rd_data = rd_valid_ff ? ram_rdata : VALUE_W'(rd_addr_ff);
      if (mode_ff) begin
         stop = (idx_ff == pos_ff);
      end else begin
         stop = (rd_data == sym_ff) || (idx_ff == IDX_W'(ALPHABET_SIZE - 1));
      end

      mode_in      = csr_write_en ? csr_write_data : mode_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      sym_in       = sym_ff;
      carry_in     = carry_ff;
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;

      if (cmd.start) begin
         pos_in   = sat_pos(req_value);
         last_in  = req_last;
         sym_in   = req_value;
         carry_in = req_value;
         idx_in   = '0;
         rd_addr  = mode_ff ? sat_pos(req_value) : '0;
      end

      if (cmd.fetch) begin
         sym_in   = rd_data;
         carry_in = rd_data;
         idx_in   = '0;
         rd_addr  = '0;
      end

      // Each step writes the carried entry one place back and picks up the
      // entry it displaces, so the list shifts while it is searched.
      if (cmd.walk) begin
         wr_en            = 1'b1;
         valid_in[idx_ff] = 1'b1;
         rd_addr          = idx_ff + IDX_W'(1);
         if (!stop) begin
            carry_in = rd_data;
            idx_in   = idx_ff + IDX_W'(1);
         end else if (last_ff) begin
            valid_in = '0;
         end
      end

      if (cmd.load_rsp) begin
         rsp_value_in = mode_ff ? sym_ff : sat_value(idx_ff);
         rsp_last_in  = last_ff;
      end

      if (32'(rd_addr) < ALPHABET_SIZE) begin
         rd_valid_in = valid_ff[rd_addr];
      end else begin
         rd_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         valid_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      last_ff      <= last_in;
      sym_ff       <= sym_in;
      carry_ff     <= carry_in;
      idx_ff       <= idx_in;
      rd_addr_ff   <= rd_addr;
      rd_valid_ff  <= rd_valid_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign stat.decode = mode_ff;
   assign stat.stop   = stop;
   assign rsp_value   = rsp_value_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

/* hdl/mtfc_ctrl.sv */
`timescale 1ns / 1ps

module mtfc_ctrl
   import mtfc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = stat.decode ? ST_FETCH : ST_WALK;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (stat.stop) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // The output register must be empty or emptying this cycle.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/move_to_front_codec_core.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake      Payload
// req_ch    in         valid/ready    value_in[7:0], last_in
// rsp_ch    out        valid/ready    value_out[7:0], last_out
// csr_*     in         write enable   csr_write_data = mode (0 encode, 1 decode)
//
// An item walks the list up to its byte's list position p, and decode first
// fetches entry p; a one-write, one-read RAM is walked one entry per cycle.
// Reset clears the mode and the per-entry valid bits at once, so the list
// reads as the identity with no clearing pass; block ends clear the bits too.
// A new request is taken while an earlier response waits in the output
// register; the block stalls only when a finished item finds it full.

module move_to_front_codec_core
   import mtfc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   mtfc_req_if.sink         req_ch,
   mtfc_rsp_if.source       rsp_ch,
   input  logic             csr_write_en,
   input  logic             csr_write_data
);

   cmd_type  cmd;
   stat_type stat;

   mtfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mtfc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .stat           (stat),
      .req_value      (req_ch.value_in),
      .req_last       (req_ch.last_in),
      .rsp_value      (rsp_ch.value_out),
      .rsp_last       (rsp_ch.last_out)
   );

   // A response is never loaded over one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("response loaded over a pending transfer");

   // No request is taken while the list is being walked.
   assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> !req_ch.ready)
      else $error("request accepted during list walk");

   // An accepted request starts the fetch or the walk on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (cmd.fetch || cmd.walk))
      else $error("accepted request did not start processing");

   // A loaded response is offered on the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_ch.valid)
      else $error("loaded response not presented");

endmodule
